FILE: design/imuoda_pkg.sv
// imuoda_pkg: shared constants, types and codes for the IMU offset/deadband/average block.
// No dependencies; imported by every module of the block.
`default_nettype none

package imuoda_pkg;

  // Filter configuration
  localparam int AVG_DEPTH   = 7;
  localparam int CAL_SAMPLES = 10;
  localparam int SAMPLE_BITS = 16;

  localparam int NLANE  = 6;
  localparam int RAW_W  = 16;
  localparam int AVG_W  = 33;
  localparam int GAIN_W = 16;
  localparam int THR_W  = 32;

  // Conditioning datapath
  localparam int OFF_W  = 18;
  localparam int DIFF_W = OFF_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam longint SAT_MAX = 64'd4294836225;

  // Running sum and divide by AVG_DEPTH, done a chunk per stage
  localparam int SUM_W    = AVG_W + $clog2(AVG_DEPTH);
  localparam int MAG_W    = SUM_W - 1;
  localparam int CHUNK_W  = 9;
  localparam int NCHUNK   = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int DPAD_W   = NCHUNK * CHUNK_W;
  localparam int REM_W    = $clog2(AVG_DEPTH);
  localparam int VAL_W    = REM_W + CHUNK_W;
  localparam int RSH      = VAL_W + REM_W;
  localparam longint RECIP = ((longint'(1) << RSH) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W  = RSH + 1;

  // Calibration sum and divide by CAL_SAMPLES
  localparam int CMAG_W    = SAMPLE_BITS - 1 + $clog2(CAL_SAMPLES + 1);
  localparam int CSUM_W    = CMAG_W + 1;
  localparam int CAL_SH    = CMAG_W + $clog2(CAL_SAMPLES + 1);
  localparam longint CAL_RECIP = ((longint'(1) << CAL_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int CREC_W    = CAL_SH + 1;
  localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);

  // Pipeline: diff, product, conditioned, sum, magnitude, divide chunks, output
  localparam int NSTG = 5 + NCHUNK + 1;

  // Register file
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0] ONE_G_RST = 16'd256;

  typedef enum logic [2:0] {
    REG_ACCEL_GAIN = 3'd0,
    REG_GYRO_GAIN  = 3'd1,
    REG_ACCEL_THR  = 3'd2,
    REG_GYRO_THR   = 3'd3,
    REG_ONE_G      = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CAL,
    ST_DIV,
    ST_FIN,
    ST_RUN
  } cal_state_t;

  typedef struct packed {
    logic adv;       // whole pipeline advances
    logic cal_add;   // calibration transaction accepted
    logic div_go;    // offset division, multiply step
    logic fin_go;    // offset division, final step
    logic hist_upd;  // conditioned sample enters history
    logic cal_last;  // item about to enter output register is a calibration item
  } ctl_t;

endpackage

`default_nettype wire

FILE: design/imu_offset_deadband_average.sv
// imu_offset_deadband_average: top level, register file, six channel lanes and the
// output register that merges them. Depends on imuoda_pkg, imuoda_ctrl, imuoda_lane.
//
//  Port group   Direction  Handshake             Contents
//  in_*         input      in_valid / in_ready   six raw 16-bit counts per transaction
//  out_*        output     out_valid / out_ready six 33-bit averages + calibrating flag
//  psel etc.    APB        psel&penable, pready  five config registers at 4*index
//
// One transaction per cycle unless stalled; NSTG (10 at default settings) register stages:
// diff, gain multiply, saturate/deadband, running sum, magnitude, one stage per 9-bit
// digit of the divide by AVG_DEPTH, output register.
// Synchronous active-low reset clears history, sums, calibration count and the registers.
// After the last calibration transaction in_ready is low in ST_DIV and ST_FIN while the
// offsets are divided out. The whole pipeline holds when out_valid is high and out_ready low.
`default_nettype none

module imu_offset_deadband_average import imuoda_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [RAW_W-1:0] in_raw_accel_x,
  input  wire logic signed [RAW_W-1:0] in_raw_accel_y,
  input  wire logic signed [RAW_W-1:0] in_raw_accel_z,
  input  wire logic signed [RAW_W-1:0] in_raw_gyro_x,
  input  wire logic signed [RAW_W-1:0] in_raw_gyro_y,
  input  wire logic signed [RAW_W-1:0] in_raw_gyro_z,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [AVG_W-1:0]      out_avg_accel_x,
  output logic signed [AVG_W-1:0]      out_avg_accel_y,
  output logic signed [AVG_W-1:0]      out_avg_accel_z,
  output logic signed [AVG_W-1:0]      out_avg_rate_x,
  output logic signed [AVG_W-1:0]      out_avg_rate_y,
  output logic signed [AVG_W-1:0]      out_avg_rate_z,
  output logic                         out_calibrating,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  // ---- register file ----
  logic [GAIN_W-1:0] accel_gain_r;
  logic [GAIN_W-1:0] gyro_gain_r;
  logic [THR_W-1:0]  accel_thr_r;
  logic [THR_W-1:0]  gyro_thr_r;
  logic [GAIN_W-1:0] one_g_r;
  logic              wr_en;
  reg_idx_t          ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_gain_r <= GAIN_RST;
      gyro_gain_r  <= GAIN_RST;
      accel_thr_r  <= '0;
      gyro_thr_r   <= '0;
      one_g_r      <= ONE_G_RST;
    end else if (wr_en) begin
      case (ridx)
        REG_ACCEL_GAIN: accel_gain_r <= pwdata[GAIN_W-1:0];
        REG_GYRO_GAIN:  gyro_gain_r  <= pwdata[GAIN_W-1:0];
        REG_ACCEL_THR:  accel_thr_r  <= pwdata[THR_W-1:0];
        REG_GYRO_THR:   gyro_thr_r   <= pwdata[THR_W-1:0];
        REG_ONE_G:      one_g_r      <= pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ACCEL_GAIN: prdata = DATA_W'(accel_gain_r);
      REG_GYRO_GAIN:  prdata = DATA_W'(gyro_gain_r);
      REG_ACCEL_THR:  prdata = DATA_W'(accel_thr_r);
      REG_GYRO_THR:   prdata = DATA_W'(gyro_thr_r);
      REG_ONE_G:      prdata = DATA_W'(one_g_r);
      default:        prdata = '0;
    endcase
  end

  // ---- control ----
  ctl_t ctl;

  imuoda_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_cal_o   (out_calibrating),
    .ctl_o       (ctl)
  );

  // ---- lanes ----
  // Lane order follows the outputs; rate x comes from gyro y and rate y from gyro x.
  // Each lane calibrates on the raw channel it carries.
  logic [RAW_W-1:0]        lane_raw [NLANE];
  logic signed [AVG_W-1:0] lane_avg [NLANE];
  logic signed [AVG_W-1:0] avg_r    [NLANE];

  assign lane_raw[0] = in_raw_accel_x;
  assign lane_raw[1] = in_raw_accel_y;
  assign lane_raw[2] = in_raw_accel_z;
  assign lane_raw[3] = in_raw_gyro_y;
  assign lane_raw[4] = in_raw_gyro_x;
  assign lane_raw[5] = in_raw_gyro_z;

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [GAIN_W-1:0] gain;
    logic [THR_W-1:0]  thr;
    logic [GAIN_W-1:0] onesub;

    assign gain   = (l < 3) ? accel_gain_r : gyro_gain_r;
    assign thr    = (l < 3) ? accel_thr_r  : gyro_thr_r;
    // one g is taken out of the accel z offset only
    assign onesub = (l == 2) ? one_g_r : '0;

    imuoda_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (ctl),
      .raw_i    (lane_raw[l]),
      .gain_i   (gain),
      .thr_i    (thr),
      .onesub_i (onesub),
      .avg_o    (lane_avg[l])
    );
  end

  // ---- merge / output register ----
  // calibration transactions report zero averages
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int l = 0; l < NLANE; l++) begin
        avg_r[l] <= ctl.cal_last ? '0 : lane_avg[l];
      end
    end
  end

  assign out_avg_accel_x = avg_r[0];
  assign out_avg_accel_y = avg_r[1];
  assign out_avg_accel_z = avg_r[2];
  assign out_avg_rate_x  = avg_r[3];
  assign out_avg_rate_y  = avg_r[4];
  assign out_avg_rate_z  = avg_r[5];

endmodule

`default_nettype wire

FILE: design/imuoda_cdiv.sv
// imuoda_cdiv: pipelined divide of a magnitude by AVG_DEPTH, one CHUNK_W-bit digit per stage.
// Depends on imuoda_pkg.
`default_nettype none

module imuoda_cdiv import imuoda_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en_i,
  input  wire logic [DPAD_W-1:0] mag_i,
  input  wire logic              neg_i,
  output logic      [DPAD_W-1:0] quot_o,
  output logic                   neg_o
);

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [VAL_W-1:0]   DIV_C   = VAL_W'(AVG_DEPTH);

  logic [DPAD_W-1:0] x_r   [NCHUNK];
  logic [REM_W-1:0]  rem_r [NCHUNK];
  logic              neg_r [NCHUNK];

  logic [DPAD_W-1:0] xin [NCHUNK];
  logic [REM_W-1:0]  rin [NCHUNK];
  logic              nin [NCHUNK];

  for (genvar j = 0; j < NCHUNK; j++) begin : g_stg
    localparam int CI = NCHUNK - 1 - j;

    logic [VAL_W-1:0]         v;
    logic [VAL_W+RECIP_W-1:0] pm;
    logic [CHUNK_W-1:0]       q;
    logic [VAL_W-1:0]         r;
    logic [DPAD_W-1:0]        x_nxt;

    if (j == 0) begin : g_first
      assign xin[j] = mag_i;
      assign rin[j] = '0;
      assign nin[j] = neg_i;
    end else begin : g_next
      assign xin[j] = x_r[j-1];
      assign rin[j] = rem_r[j-1];
      assign nin[j] = neg_r[j-1];
    end

    // remainder:digit divided by reciprocal multiply; digit < 2^CHUNK_W always
    assign v  = {rin[j], xin[j][CI*CHUNK_W +: CHUNK_W]};
    assign pm = (VAL_W+RECIP_W)'(v) * (VAL_W+RECIP_W)'(RECIP_C);
    assign q  = pm[RSH +: CHUNK_W];
    assign r  = v - VAL_W'(q) * DIV_C;

    always_comb begin
      x_nxt = xin[j];
      x_nxt[CI*CHUNK_W +: CHUNK_W] = q;
    end

    always_ff @(posedge clk) begin
      if (en_i) begin
        x_r[j]   <= x_nxt;
        rem_r[j] <= r[REM_W-1:0];
        neg_r[j] <= nin[j];
      end
    end
  end

  assign quot_o = x_r[NCHUNK-1];
  assign neg_o  = neg_r[NCHUNK-1];

endmodule

`default_nettype wire

FILE: design/imuoda_lane.sv
// imuoda_lane: one sensor channel: calibration sum and offset, gain, deadband,
// history with running sum, and the averaging divide. Depends on imuoda_pkg, imuoda_cdiv.
`default_nettype none

module imuoda_lane import imuoda_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ctl_t                    ctl_i,
  input  wire logic [RAW_W-1:0]        raw_i,
  input  wire logic [GAIN_W-1:0]       gain_i,
  input  wire logic [THR_W-1:0]        thr_i,
  input  wire logic [GAIN_W-1:0]       onesub_i,
  output logic signed [AVG_W-1:0]      avg_o
);

  localparam logic [CREC_W-1:0] CAL_RECIP_C = CREC_W'(CAL_RECIP);

  logic signed [SAMPLE_BITS-1:0] smp;
  assign smp = raw_i[SAMPLE_BITS-1:0];

  // ---- calibration ----
  logic signed [CSUM_W-1:0]     csum_r;
  logic                         cneg_r;
  logic [CMAG_W+CREC_W-1:0]     cprod_r;
  logic [CMAG_W-1:0]            cmag;
  logic [CMAG_W-1:0]            cq;
  logic signed [OFF_W-1:0]      off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= '0;
    end else if (ctl_i.cal_add) begin
      csum_r <= csum_r + CSUM_W'(smp);
    end
  end

  assign cmag = csum_r[CSUM_W-1] ? CMAG_W'(-csum_r) : CMAG_W'(csum_r);
  assign cq   = cprod_r[CAL_SH +: CMAG_W];

  always_ff @(posedge clk) begin
    if (ctl_i.div_go) begin
      cneg_r  <= csum_r[CSUM_W-1];
      cprod_r <= (CMAG_W+CREC_W)'(cmag) * (CMAG_W+CREC_W)'(CAL_RECIP_C);
    end
    if (ctl_i.fin_go) begin
      off_r <= (cneg_r ? -OFF_W'(cq) : OFF_W'(cq)) - OFF_W'(onesub_i);
    end
  end

  // ---- conditioning ----
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [AVG_W-1:0]  cur_r;

  logic                     pneg;
  logic [PROD_W-2:0]        magp;
  logic [THR_W-1:0]         smag;
  logic signed [AVG_W-1:0]  sval;
  logic signed [AVG_W-1:0]  cur_nxt;

  always_comb begin
    pneg    = prod_r[PROD_W-1];
    magp    = pneg ? (PROD_W-1)'(-prod_r) : (PROD_W-1)'(prod_r);
    smag    = (magp > (PROD_W-1)'(SAT_MAX)) ? THR_W'(SAT_MAX) : magp[THR_W-1:0];
    sval    = {1'b0, smag};
    cur_nxt = (smag >= thr_i) ? (pneg ? -sval : sval) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      diff_r <= DIFF_W'(smp) - DIFF_W'(off_r);
      prod_r <= PROD_W'(diff_r) * PROD_W'($signed({1'b0, gain_i}));
      cur_r  <= cur_nxt;
    end
  end

  // ---- history and running sum ----
  logic signed [AVG_W-1:0] hist_r [AVG_DEPTH];
  logic signed [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AVG_DEPTH; k++) begin
        hist_r[k] <= '0;
      end
      sum_r <= '0;
    end else if (ctl_i.hist_upd) begin
      hist_r[0] <= cur_r;
      for (int k = 1; k < AVG_DEPTH; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
      sum_r <= sum_r + SUM_W'(cur_r) - SUM_W'(hist_r[AVG_DEPTH-1]);
    end
  end

  // ---- magnitude, divide, sign ----
  logic [DPAD_W-1:0] mag_r;
  logic              mneg_r;
  logic [DPAD_W-1:0] quot;
  logic              qneg;
  logic signed [AVG_W-1:0] qv;

  // magnitude is zero-extended into the padded divider width
  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      mneg_r <= sum_r[SUM_W-1];
      mag_r  <= DPAD_W'($unsigned(sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r)));
    end
  end

  imuoda_cdiv u_cdiv (
    .clk    (clk),
    .en_i   (ctl_i.adv),
    .mag_i  (mag_r),
    .neg_i  (mneg_r),
    .quot_o (quot),
    .neg_o  (qneg)
  );

  // truncation toward zero: divide the magnitude, then restore the sign
  assign qv    = quot[AVG_W-1:0];
  assign avg_o = qneg ? -qv : qv;

endmodule

`default_nettype wire

FILE: design/imuoda_ctrl.sv
// imuoda_ctrl: pipeline valid/flag shift, flow control and calibration sequencer.
// Depends on imuoda_pkg.
`default_nettype none

module imuoda_ctrl import imuoda_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic      out_cal_o,
  output ctl_t      ctl_o
);

  cal_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NSTG-1:0]  v_r;
  logic [NSTG-1:0]  c_r;
  logic             adv;
  logic             accept;
  logic             in_cal;

  assign adv        = !v_r[NSTG-1] || out_ready_i;
  assign in_ready_o = adv && (state_r == ST_CAL || state_r == ST_RUN);
  assign accept     = in_valid_i && in_ready_o;
  assign in_cal     = (state_r == ST_CAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CAL;
      cnt_r   <= '0;
      v_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        v_r <= {v_r[NSTG-2:0], accept};
        c_r <= {c_r[NSTG-2:0], in_cal};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CAL: begin
        if (accept) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(CAL_SAMPLES - 1)) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CAL;
      end
    endcase
  end

  always_comb begin
    ctl_o.adv      = adv;
    ctl_o.cal_add  = accept && in_cal;
    ctl_o.div_go   = (state_r == ST_DIV);
    ctl_o.fin_go   = (state_r == ST_FIN);
    ctl_o.hist_upd = adv && v_r[2] && !c_r[2];
    ctl_o.cal_last = c_r[NSTG-2];
  end

  assign out_valid_o = v_r[NSTG-1];
  assign out_cal_o   = c_r[NSTG-1];

endmodule

`default_nettype wire

FILE: tb/imu_offset_deadband_average_tb.sv
// imu_offset_deadband_average_tb: self-checking testbench for the IMU offset, deadband and
// seven-sample average block. Depends only on imuoda_pkg and imu_offset_deadband_average.
// A transaction-level predictor runs beside the DUT; every output transaction is compared.

module imu_offset_deadband_average_tb;
  import imuoda_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = NSTG + 4;    // pipeline depth plus a little slack
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 5;
  localparam int NUM_REG_SLOTS = 8;           // word slots the 5-bit paddr can reach
  localparam int EDGE_K        = 5;           // raw distance used for the deadband edge
  localparam longint RAW_MAX   = (longint'(1) << (RAW_W - 1)) - 1;
  localparam longint RAW_MIN   = -(longint'(1) << (RAW_W - 1));

  // Lane order of the raw sample (input side)
  localparam int AX = 0, AY = 1, AZ = 2, GX = 3, GY = 4, GZ = 5;
  // Lane order of the result: rate x comes from gyro y, rate y from gyro x
  localparam int RX = 3, RY = 4, RZ = 5;

  typedef logic [NLANE-1:0][RAW_W-1:0] sample_t;
  typedef struct packed {
    logic                          calibrating;
    logic [NLANE-1:0][AVG_W-1:0]   avg;
  } result_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic signed [AVG_W-1:0] out_avg_accel_x, out_avg_accel_y, out_avg_accel_z;
  logic signed [AVG_W-1:0] out_avg_rate_x, out_avg_rate_y, out_avg_rate_z;
  logic                    out_calibrating;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  imu_offset_deadband_average dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_raw_accel_x  (in_sample[AX]),
    .in_raw_accel_y  (in_sample[AY]),
    .in_raw_accel_z  (in_sample[AZ]),
    .in_raw_gyro_x   (in_sample[GX]),
    .in_raw_gyro_y   (in_sample[GY]),
    .in_raw_gyro_z   (in_sample[GZ]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_avg_accel_x (out_avg_accel_x),
    .out_avg_accel_y (out_avg_accel_y),
    .out_avg_accel_z (out_avg_accel_z),
    .out_avg_rate_x  (out_avg_rate_x),
    .out_avg_rate_y  (out_avg_rate_y),
    .out_avg_rate_z  (out_avg_rate_z),
    .out_calibrating (out_calibrating),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: register shadows, calibration, offsets and averaging history
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] accel_gain_q = GAIN_RST;
  logic [GAIN_W-1:0] gyro_gain_q  = GAIN_RST;
  logic [GAIN_W-1:0] one_g_q      = ONE_G_RST;
  logic [THR_W-1:0]  accel_thr_q  = '0;
  logic [THR_W-1:0]  gyro_thr_q   = '0;

  longint hist_q   [AVG_DEPTH][NLANE] = '{default: 0};
  longint cal_sum  [NLANE] = '{default: 0};
  longint lane_off [NLANE] = '{default: 0};
  int     cal_seen = 0;

  result_t pending [$];       // expected output transactions, oldest first
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;    // sender inserts gaps
  bit      stall_on = 1'b1;   // receiver drops out_ready
  int      ready_hold = 0;

  // Offset removal, gain, saturation at +/-SAT_MAX, then deadband (equal is kept)
  function automatic longint scale_and_deadband(longint raw, longint off, longint gain,
                                                longint thr);
    longint v;
    v = (raw - off) * gain;
    if (v > SAT_MAX) v = SAT_MAX;
    else if (v < -SAT_MAX) v = -SAT_MAX;
    if ((v < 0 ? -v : v) < thr) v = 0;
    return v;
  endfunction

  // Advances the predictor by one accepted sample and returns the expected result
  function automatic result_t predict_average(sample_t s);
    result_t r;
    longint  raw [NLANE];
    longint  cur [NLANE];
    longint  acc;
    int      i, d;
    r = '0;
    for (i = 0; i < NLANE; i++) raw[i] = longint'($signed(s[i]));

    // calibration transaction: accumulate, averages read zero, history untouched
    if (cal_seen < CAL_SAMPLES) begin
      for (i = 0; i < NLANE; i++) cal_sum[i] += raw[i];
      cal_seen++;
      if (cal_seen == CAL_SAMPLES) begin
        for (i = 0; i < NLANE; i++) lane_off[i] = cal_sum[i] / CAL_SAMPLES;
        lane_off[AZ] -= longint'(one_g_q);   // one_g sampled once, here
      end
      r.calibrating = 1'b1;
      return r;
    end

    cur[AX] = scale_and_deadband(raw[AX], lane_off[AX], accel_gain_q, accel_thr_q);
    cur[AY] = scale_and_deadband(raw[AY], lane_off[AY], accel_gain_q, accel_thr_q);
    cur[AZ] = scale_and_deadband(raw[AZ], lane_off[AZ], accel_gain_q, accel_thr_q);
    cur[RX] = scale_and_deadband(raw[GY], lane_off[GY], gyro_gain_q, gyro_thr_q);
    cur[RY] = scale_and_deadband(raw[GX], lane_off[GX], gyro_gain_q, gyro_thr_q);
    cur[RZ] = scale_and_deadband(raw[GZ], lane_off[GZ], gyro_gain_q, gyro_thr_q);

    for (d = AVG_DEPTH - 1; d > 0; d--)
      for (i = 0; i < NLANE; i++) hist_q[d][i] = hist_q[d-1][i];
    for (i = 0; i < NLANE; i++) begin
      hist_q[0][i] = cur[i];
      acc = 0;
      for (d = 0; d < AVG_DEPTH; d++) acc += hist_q[d][i];
      r.avg[i] = AVG_W'(acc / AVG_DEPTH);   // signed divide truncates toward zero
    end
    return r;
  endfunction

  function automatic string lane_label(int i);
    case (i)
      AX:      return "avg_accel_x";
      AY:      return "avg_accel_y";
      AZ:      return "avg_accel_z";
      RX:      return "avg_rate_x";
      RY:      return "avg_rate_y";
      default: return "avg_rate_z";
    endcase
  endfunction

  function automatic void note_mismatch(string what, longint want, longint got);
    if (mismatches < REPORT_MAX)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [RAW_W-1:0] clamp_count(longint v);
    if (v > RAW_MAX) v = RAW_MAX;
    if (v < RAW_MIN) v = RAW_MIN;
    return RAW_W'(v);
  endfunction

  // Mostly full-range counts, some extremes, some close to the lane offset so that
  // small magnitudes meet the deadband
  function automatic logic [RAW_W-1:0] draw_count(int lane);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return RAW_W'(RAW_MAX);
        1:       return RAW_W'(RAW_MIN);
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 35) return clamp_count(lane_off[lane] + int'($urandom_range(0, 64)) - 32);
    return RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      i;
    for (i = 0; i < NLANE; i++) s[i] = draw_count(i);
    return s;
  endfunction

  // Sample whose corrected value is +/-k on every lane that can reach it
  function automatic sample_t edge_sample(int k);
    sample_t s;
    longint  want;
    int      i;
    for (i = 0; i < NLANE; i++) begin
      want = lane_off[i] + k;
      if (want > RAW_MAX || want < RAW_MIN) want = lane_off[i] - k;
      s[i] = clamp_count(want);
    end
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_RST;
      3:       return GAIN_W'(1);
      default: return GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
    endcase
  endfunction

  function automatic logic [THR_W-1:0] draw_thr();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom() >> $urandom_range(8, 28);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks; all start and end just after a falling edge
  // ---------------------------------------------------------------------------
  // One input transaction; the expectation is logged at the accepting edge
  task automatic send_sample(sample_t s);
    int gap;
    in_sample = s;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending.push_back(predict_average(s));
    @(negedge clk);
    in_valid = 1'b0;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
  endtask

  // APB write: setup phase, access phase, write lands when pready is seen
  task automatic write_reg(int idx, logic [DATA_W-1:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_W'(idx * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACCEL_GAIN: accel_gain_q = value[GAIN_W-1:0];
      REG_GYRO_GAIN:  gyro_gain_q  = value[GAIN_W-1:0];
      REG_ACCEL_THR:  accel_thr_q  = value[THR_W-1:0];
      REG_GYRO_THR:   gyro_thr_q   = value[THR_W-1:0];
      REG_ONE_G:      one_g_q      = value[GAIN_W-1:0];
      default:        ;   // undecoded slot, write must be dropped
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_ACCEL_GAIN: want = DATA_W'(accel_gain_q);
      REG_GYRO_GAIN:  want = DATA_W'(gyro_gain_q);
      REG_ACCEL_THR:  want = DATA_W'(accel_thr_q);
      REG_GYRO_THR:   want = DATA_W'(gyro_thr_q);
      default:        want = DATA_W'(one_g_q);
    endcase
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = ADDR_W'(int'(idx) * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_mismatch($sformatf("readback %s", idx.name()), longint'(want), longint'(prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Hold the sender until the DUT has returned everything, then let the pipe settle
  task automatic wait_drained();
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values, full-scale and zero writes with readback, undecoded slots ignored.
  // one_g is left at its maximum so the z offset lands below the raw range
  // and the positive saturation path becomes reachable.
  task automatic test_register_access();
    int k;
    for (k = 0; k <= int'(REG_ONE_G); k++) check_reg(reg_idx_t'(k));
    write_reg(REG_ACCEL_GAIN, '1);
    write_reg(REG_GYRO_GAIN, '0);
    write_reg(REG_ACCEL_THR, '1);
    write_reg(REG_GYRO_THR, '1);
    write_reg(REG_ONE_G, DATA_W'({GAIN_W{1'b1}}));
    for (k = 0; k <= int'(REG_ONE_G); k++) check_reg(reg_idx_t'(k));
    for (k = int'(REG_ONE_G) + 1; k < NUM_REG_SLOTS; k++) write_reg(k, '0);
    for (k = 0; k <= int'(REG_ONE_G); k++) check_reg(reg_idx_t'(k));
  endtask

  // Calibration transactions: full-scale both ways, then random; registers are
  // rewritten halfway through while the block is idle
  task automatic test_calibration();
    int n;
    send_sample({NLANE{RAW_W'(RAW_MAX)}});
    send_sample({NLANE{RAW_W'(RAW_MIN)}});
    for (n = 2; n < CAL_SAMPLES; n++) begin
      if (n == CAL_SAMPLES / 2) begin
        wait_drained();
        write_reg(REG_ACCEL_GAIN, DATA_W'(GAIN_RST));
        write_reg(REG_GYRO_GAIN, DATA_W'(GAIN_RST));
      end
      send_sample(random_sample());
    end
  endtask

  // Zero gain, then maximum gain with full-scale inputs (z saturates) and a
  // sample sitting exactly on the offsets
  task automatic test_gain_extremes();
    wait_drained();
    write_reg(REG_ACCEL_GAIN, '0);
    write_reg(REG_GYRO_GAIN, '0);
    write_reg(REG_ACCEL_THR, '0);
    write_reg(REG_GYRO_THR, '0);
    send_sample(random_sample());
    wait_drained();
    write_reg(REG_ACCEL_GAIN, DATA_W'({GAIN_W{1'b1}}));
    write_reg(REG_GYRO_GAIN, DATA_W'({GAIN_W{1'b1}}));
    send_sample({NLANE{RAW_W'(RAW_MAX)}});
    send_sample({NLANE{RAW_W'(RAW_MIN)}});
    send_sample(edge_sample(0));
  endtask

  // Magnitude equal to threshold survives, one step below is zeroed, both signs;
  // then the largest threshold kills every lane
  task automatic test_deadband_edge();
    wait_drained();
    write_reg(REG_ACCEL_GAIN, DATA_W'(GAIN_RST));
    write_reg(REG_GYRO_GAIN, DATA_W'(3));
    write_reg(REG_ACCEL_THR, DATA_W'(GAIN_RST) * EDGE_K);
    write_reg(REG_GYRO_THR, DATA_W'(3 * EDGE_K));
    send_sample(edge_sample(EDGE_K));
    send_sample(edge_sample(EDGE_K - 1));
    send_sample(edge_sample(-EDGE_K));
    wait_drained();
    write_reg(REG_ACCEL_THR, '1);
    write_reg(REG_GYRO_THR, '1);
    send_sample(random_sample());
  endtask

  // one_g written after calibration must leave the offsets alone
  task automatic test_late_one_g();
    wait_drained();
    write_reg(REG_ONE_G, '0);
    check_reg(REG_ONE_G);
    write_reg(REG_ACCEL_THR, '0);
    write_reg(REG_GYRO_THR, '0);
    send_sample(random_sample());
    send_sample(random_sample());
  endtask

  // Random traffic in phases, each with fresh registers and its own flow-control mix:
  // full rate, sender gaps only, receiver stalls only, then both
  task automatic test_random_stream();
    int phase, n;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      write_reg(REG_ACCEL_GAIN, DATA_W'(draw_gain()));
      write_reg(REG_GYRO_GAIN, DATA_W'(draw_gain()));
      write_reg(REG_ACCEL_THR, draw_thr());
      write_reg(REG_GYRO_THR, draw_thr());
      write_reg(REG_ONE_G, DATA_W'(draw_gain()));
      idle_on  = (phase == 1) || (phase >= 3);
      stall_on = (phase >= 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2) wait_drained();
        send_sample(random_sample());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: out_ready pattern, updated on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    int r;
    if (!stall_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 3);
      end else if (r < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  // Checker: each output transaction against the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    int      i;
    if (rst_n && out_valid && out_ready) begin
      got.calibrating = out_calibrating;
      got.avg = {out_avg_rate_z, out_avg_rate_y, out_avg_rate_x,
                 out_avg_accel_z, out_avg_accel_y, out_avg_accel_x};
      if (pending.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected output transaction, calibrating=%0b", got.calibrating);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (got.calibrating !== want.calibrating)
          note_mismatch("calibrating", longint'(want.calibrating), longint'(got.calibrating));
        for (i = 0; i < NLANE; i++)
          if (got.avg[i] !== want.avg[i])
            note_mismatch(lane_label(i), longint'($signed(want.avg[i])),
                          longint'($signed(got.avg[i])));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_offset_deadband_average_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_calibration();
    test_gain_extremes();
    test_deadband_edge();
    test_late_one_g();
    test_random_stream();

    wait_drained();
    if (mismatches == 0) $display("imu_offset_deadband_average_tb: PASS");
    else $display("imu_offset_deadband_average_tb: FAIL");
    $finish;
  end

endmodule
